[sv/grid_path_backtracking_solver_macros.svh]
// assertion macros shared by the solver rtl
// expects signals named clock and reset in the including scope
`ifndef GRID_PATH_BACKTRACKING_SOLVER_MACROS_SVH
`define GRID_PATH_BACKTRACKING_SOLVER_MACROS_SVH

// condition that must hold at every edge out of reset
`define GPBS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define GPBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GPBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gpbs_pkg.sv]
// shared types and constants of the grid path solver
// no dependencies
package gpbs_pkg;

   localparam int unsigned ROWS_DEF  = 8;
   localparam int unsigned COLS_DEF  = 16;
   localparam int unsigned ROW_IDX_W = 3;
   localparam int unsigned CELLS_W   = 16;
   localparam int unsigned LEN_W     = 5;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_SOLVE = 1'b1
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load_row;
      logic solve_init;
      logic push;
      logic mark_goal;
      logic pop;
      logic go_right;
      logic go_left;
      logic clr_mark;
      logic emit_rd;
      logic emit_ld;
      logic emit_next;
   } gpbs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_goal;
      logic can_push;
      logic depth_zero;
      logic move_right;
      logic emit_last;
   } gpbs_sts_type;

endpackage

[sv/gpbs_ifs.sv]
// request and response channel interfaces of the grid path solver
// depends on gpbs_pkg
interface gpbs_req_if import gpbs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   op_type               command;
   logic [ROW_IDX_W-1:0] row_index;
   logic [CELLS_W-1:0]   row_cells;

   modport source (output valid, command, row_index, row_cells, input ready);
   modport sink   (input valid, command, row_index, row_cells, output ready);
endinterface

interface gpbs_rsp_if import gpbs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [ROW_IDX_W-1:0] out_row;
   logic [CELLS_W-1:0]   path_bits;
   logic [LEN_W-1:0]     path_length;
   logic                 last_row;

   modport source (output valid, found, out_row, path_bits, path_length, last_row,
                   input ready);
   modport sink   (input valid, found, out_row, path_bits, path_length, last_row,
                   output ready);
endinterface

[sv/gpbs_ram.sv]
// generic single write port ram with registered read
// no dependencies
module gpbs_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 8,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gpbs_ctrl.sv]
// sequencer for loads, the depth-first walk and row emission
// depends on gpbs_pkg
module gpbs_ctrl import gpbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  op_type       req_command,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  gpbs_sts_type sts,
   output gpbs_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_OPEN,
      S_POP,
      S_POPD,
      S_CLR,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load_row = 1'b1;
               end else begin
                  cmd.solve_init = 1'b1;
                  state_in       = S_CHECK;
               end
            end
         end
         // grid and path rows of the current cell are being read
         S_CHECK: state_in = S_OPEN;
         S_OPEN: begin
            if (sts.at_goal) begin
               cmd.mark_goal = 1'b1;
               state_in      = S_EMIT_RD;
            end else if (sts.can_push) begin
               cmd.push = 1'b1;
               state_in = S_CHECK;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sts.depth_zero) begin
               state_in = S_EMIT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POPD;
            end
         end
         S_POPD: begin
            if (!sts.move_right) begin
               cmd.go_right = 1'b1;
               state_in     = S_CHECK;
            end else begin
               cmd.go_left = 1'b1;
               state_in    = S_CLR;
            end
         end
         S_CLR: begin
            cmd.clr_mark = 1'b1;
            state_in     = S_POP;
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.emit_ld  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (sts.emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/gpbs_dp.sv]
// datapath: grid, path and move stack rams, position, depth and output registers
// depends on gpbs_pkg and gpbs_ram
module gpbs_dp import gpbs_pkg::*; #(
   parameter int unsigned ROWS = ROWS_DEF,
   parameter int unsigned COLS = COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gpbs_cmd_type         cmd,
   output gpbs_sts_type         sts,
   input  logic [ROW_IDX_W-1:0] req_row_index,
   input  logic [CELLS_W-1:0]   req_row_cells,
   output logic                 rsp_found,
   output logic [ROW_IDX_W-1:0] rsp_out_row,
   output logic [CELLS_W-1:0]   rsp_path_bits,
   output logic [LEN_W-1:0]     rsp_path_length,
   output logic                 rsp_last_row
);

   localparam int unsigned SD  = ROWS + COLS - 1;
   localparam int unsigned AW  = $clog2(ROWS);
   localparam int unsigned CIW = $clog2(COLS);
   localparam int unsigned RW  = $clog2(ROWS + 1);
   localparam int unsigned CLW = $clog2(COLS + 1);
   localparam int unsigned DW  = $clog2(SD + 1);
   localparam int unsigned SAW = $clog2(SD);
   localparam int unsigned IXW = AW + ROW_IDX_W;

   logic [RW-1:0]  row_ff, row_in;
   logic [CLW-1:0] col_ff, col_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [AW-1:0]  emit_ff, emit_in;
   logic           found_ff, found_in;
   logic [ROWS-1:0] grid_vld_ff, grid_vld_in;
   logic [ROWS-1:0] path_vld_ff, path_vld_in;
   logic           grid_rv_ff, path_rv_ff;

   logic                 found_o_ff;
   logic [ROW_IDX_W-1:0] out_row_ff;
   logic [CELLS_W-1:0]   path_bits_ff;
   logic [LEN_W-1:0]     path_length_ff;
   logic                 last_row_ff;

   logic [IXW-1:0]           idx_wide;
   logic                     load_ok;
   logic [COLS+CELLS_W-1:0]  cells_wide;
   logic [COLS-1:0]          col_bit;
   logic [COLS-1:0]          grid_rdata, path_rdata, grid_row, path_row;
   logic                     in_grid;
   logic [AW-1:0]            cur_addr, path_raddr;
   logic                     path_we;
   logic [COLS-1:0]          path_wdata;
   logic [DW-1:0]            depth_m1;
   logic                     stack_rdata;
   logic [DW+LEN_W-1:0]      len_wide;
   logic [IXW-1:0]           emit_wide;
   logic [COLS+CELLS_W-1:0]  path_wide;

   assign idx_wide   = IXW'(req_row_index);
   assign load_ok    = cmd.load_row && (idx_wide < IXW'(ROWS));
   assign cells_wide = (COLS + CELLS_W)'(req_row_cells);

   assign cur_addr   = row_ff[AW-1:0];
   assign col_bit    = {{(COLS - 1){1'b0}}, 1'b1} << col_ff[CIW-1:0];
   assign in_grid    = (row_ff < RW'(ROWS)) && (col_ff < CLW'(COLS));
   // rows never written since reset or this solve read as zero
   assign grid_row   = grid_rv_ff ? grid_rdata : '0;
   assign path_row   = path_rv_ff ? path_rdata : '0;

   assign path_raddr = cmd.emit_rd ? emit_ff : cur_addr;
   assign path_we    = cmd.push || cmd.mark_goal || cmd.clr_mark;
   assign path_wdata = cmd.clr_mark ? (path_row & ~col_bit) : (path_row | col_bit);
   assign depth_m1   = depth_ff - DW'(1);

   gpbs_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_grid_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data (cells_wide[COLS-1:0]),
      .rd_addr (cur_addr),
      .rd_data (grid_rdata)
   );

   gpbs_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_path_ram (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (cur_addr),
      .wr_data (path_wdata),
      .rd_addr (path_raddr),
      .rd_data (path_rdata)
   );

   // 0 = step down, 1 = step right
   gpbs_ram #(.WIDTH(1), .DEPTH(SD)) u_stack_ram (
      .clock   (clock),
      .wr_en   (cmd.push || cmd.go_right),
      .wr_addr (depth_ff[SAW-1:0]),
      .wr_data (cmd.go_right),
      .rd_addr (depth_m1[SAW-1:0]),
      .rd_data (stack_rdata)
   );

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      depth_in    = depth_ff;
      emit_in     = emit_ff;
      found_in    = found_ff;
      grid_vld_in = grid_vld_ff;
      path_vld_in = path_vld_ff;
      if (load_ok) begin
         grid_vld_in[idx_wide[AW-1:0]] = 1'b1;
      end
      if (path_we) begin
         path_vld_in[cur_addr] = 1'b1;
      end
      if (cmd.solve_init) begin
         row_in      = '0;
         col_in      = '0;
         depth_in    = '0;
         emit_in     = '0;
         found_in    = 1'b0;
         path_vld_in = '0;
      end
      if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
         row_in   = row_ff + RW'(1);
      end
      if (cmd.mark_goal) begin
         found_in = 1'b1;
      end
      if (cmd.pop) begin
         depth_in = depth_m1;
      end
      if (cmd.go_right) begin
         row_in   = row_ff - RW'(1);
         col_in   = col_ff + CLW'(1);
         depth_in = depth_ff + DW'(1);
      end
      if (cmd.go_left) begin
         col_in = col_ff - CLW'(1);
      end
      if (cmd.emit_next) begin
         emit_in = emit_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         depth_ff    <= '0;
         emit_ff     <= '0;
         found_ff    <= 1'b0;
         grid_vld_ff <= '0;
         path_vld_ff <= '0;
         grid_rv_ff  <= 1'b0;
         path_rv_ff  <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         depth_ff    <= depth_in;
         emit_ff     <= emit_in;
         found_ff    <= found_in;
         grid_vld_ff <= grid_vld_in;
         path_vld_ff <= path_vld_in;
         grid_rv_ff  <= grid_vld_ff[cur_addr];
         path_rv_ff  <= path_vld_ff[path_raddr];
      end
   end

   // path holds the stacked cells plus the goal
   assign len_wide  = (DW + LEN_W)'(depth_ff) + (DW + LEN_W)'(1);
   assign emit_wide = IXW'(emit_ff);
   assign path_wide = (COLS + CELLS_W)'(path_row);

   always_ff @(posedge clock) begin
      if (cmd.emit_ld) begin
         found_o_ff     <= found_ff;
         out_row_ff     <= emit_wide[ROW_IDX_W-1:0];
         path_bits_ff   <= found_ff ? path_wide[CELLS_W-1:0] : '0;
         path_length_ff <= found_ff ? len_wide[LEN_W-1:0] : '0;
         last_row_ff    <= (emit_ff == AW'(ROWS - 1));
      end
   end

   assign rsp_found       = found_o_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_path_bits   = path_bits_ff;
   assign rsp_path_length = path_length_ff;
   assign rsp_last_row    = last_row_ff;

   assign sts.at_goal    = (row_ff == RW'(ROWS - 1)) && (col_ff == CLW'(COLS - 1));
   assign sts.can_push   = in_grid && (|(grid_row & col_bit)) && (depth_ff < DW'(SD));
   assign sts.depth_zero = (depth_ff == '0);
   assign sts.move_right = stack_rdata;
   assign sts.emit_last  = (emit_ff == AW'(ROWS - 1));

endmodule

[sv/grid_path_backtracking_solver.sv]
// channel   dir  handshake      payload
// req_chan  in   valid/ready    command, row_index, row_cells
// rsp_chan  out  valid/ready    found, out_row, path_bits, path_length, last_row
//
// a load leaves the controller idle; loads may be accepted on consecutive cycles
// a solve steps forward via S_CHECK and S_OPEN, S_CHECK reading the path ram for its
// read-modify-write; a backtrack passes S_POP, S_POPD and, over a right move, S_CLR
// each result row passes S_EMIT_RD, S_EMIT_LD and S_EMIT_HOLD, which waits out any rsp stall;
// no input is taken meanwhile. reset clears the grid and path row valid bits at once, no clearing pass
//
// top level of the grid path solver; depends on gpbs_pkg, gpbs_ifs, gpbs_ctrl,
// gpbs_dp and the assertion macro header
`include "grid_path_backtracking_solver_macros.svh"

module grid_path_backtracking_solver import gpbs_pkg::*; #(
   parameter int unsigned ROWS = ROWS_DEF,
   parameter int unsigned COLS = COLS_DEF
) (
   input logic        clock,
   input logic        reset,
   gpbs_req_if.sink   req_chan,
   gpbs_rsp_if.source rsp_chan
);

   gpbs_cmd_type ctrl_cmd;
   gpbs_sts_type dp_sts;
   logic         solve_xfer;
   logic         last_xfer;
   logic         searching;

   gpbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .sts         (dp_sts),
      .cmd         (ctrl_cmd)
   );

   gpbs_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .sts             (dp_sts),
      .req_row_index   (req_chan.row_index),
      .req_row_cells   (req_chan.row_cells),
      .rsp_found       (rsp_chan.found),
      .rsp_out_row     (rsp_chan.out_row),
      .rsp_path_bits   (rsp_chan.path_bits),
      .rsp_path_length (rsp_chan.path_length),
      .rsp_last_row    (rsp_chan.last_row)
   );

   assign solve_xfer = req_chan.valid && req_chan.ready && (req_chan.command == CMD_SOLVE);
   assign last_xfer  = rsp_chan.valid && rsp_chan.ready && rsp_chan.last_row;
   assign searching  = !req_chan.ready && !rsp_chan.valid;

   `GPBS_ASSERT_ALWAYS(a_no_overlap, !(req_chan.ready && rsp_chan.valid), "ready during emission")
   `GPBS_ASSERT_NEXT(a_idle_after_last, last_xfer, req_chan.ready, "not idle after last row")
   `GPBS_ASSERT_SAME(a_push_not_goal, ctrl_cmd.push, !dp_sts.at_goal, "push from goal cell")
   `GPBS_ASSERT_NEXT(a_solve_starts, solve_xfer, searching, "solve did not start")

endmodule

[test/grid_path_backtracking_solver_tb.sv]
// self-checking testbench of the grid path solver: row loads, solves and path rows
// depends on gpbs_pkg, gpbs_ifs and grid_path_backtracking_solver
module grid_path_backtracking_solver_tb import gpbs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ROWS        = ROWS_DEF;
   localparam int unsigned COLS        = COLS_DEF;
   localparam int unsigned MAX_STEPS   = 800;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef logic [ROWS-1:0][COLS-1:0] grid_type;

   typedef struct packed {
      logic                 found;
      logic [ROW_IDX_W-1:0] row;
      logic [CELLS_W-1:0]   bits;
      logic [LEN_W-1:0]     length;
      logic                 last;
   } path_row_type;

   logic         clock = 1'b0;
   logic         reset;
   gpbs_req_if   req_chan ();
   gpbs_rsp_if   rsp_chan ();

   grid_type     maze_cells = '0;
   path_row_type path_rows_due[$];
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  stall_left = 0;
   bit           no_gaps = 1'b0;

   grid_path_backtracking_solver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // depth-first walk, down before right; returns 1 when the goal is reached
   function automatic bit trace_path(input grid_type cells, output grid_type marks,
                                     output int unsigned steps);
      bit dirs[ROWS+COLS-1];
      int depth;
      int r;
      int c;
      bit moved;
      marks = '0;
      steps = 0;
      depth = 0;
      r     = 0;
      c     = 0;
      while (1) begin
         steps++;
         if (r == ROWS-1 && c == COLS-1) begin
            marks[r][c] = 1'b1;
            return 1'b1;
         end
         if (r < ROWS && c < COLS && cells[r][c] && depth < ROWS+COLS-1) begin
            marks[r][c] = 1'b1;
            dirs[depth] = 1'b0;
            depth++;
            r++;
         end else begin
            moved = 1'b0;
            while (!moved) begin
               if (depth == 0) return 1'b0;
               depth--;
               steps++;
               if (!dirs[depth]) begin
                  r--;
                  dirs[depth] = 1'b1;
                  depth++;
                  c++;
                  moved = 1'b1;
               end else begin
                  c--;
                  marks[r][c] = 1'b0;
               end
            end
         end
      end
   endfunction

   task automatic note_transfer(input op_type cmd, input logic [ROW_IDX_W-1:0] idx,
                                input logic [CELLS_W-1:0] cells);
      grid_type     marks;
      int unsigned  steps;
      bit           found;
      path_row_type want;
      if (cmd == CMD_LOAD) begin
         maze_cells[idx] = cells;
      end else begin
         found = trace_path(maze_cells, marks, steps);
         for (int r = 0; r < ROWS; r++) begin
            want.found  = found;
            want.row    = ROW_IDX_W'(r);
            want.bits   = found ? marks[r] : '0;
            want.length = found ? LEN_W'($countones(marks)) : '0;
            want.last   = (r == ROWS-1);
            path_rows_due.push_back(want);
         end
      end
   endtask

   task automatic send_item(input op_type cmd, input logic [ROW_IDX_W-1:0] idx,
                            input logic [CELLS_W-1:0] cells);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.row_index <= idx;
      req_chan.row_cells <= cells;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      note_transfer(cmd, idx, cells);
   endtask

   // row index and cells are don't-care on a solve, so they carry noise
   task automatic send_solve();
      send_item(CMD_SOLVE, ROW_IDX_W'($urandom), CELLS_W'($urandom));
   endtask

   task automatic wait_for_rows();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (path_rows_due.size() != 0) @(posedge clock);
   endtask

   // dense grids with no way through make the walk explode, so thin them first
   task automatic solve_maze();
      grid_type    marks;
      int unsigned steps;
      int unsigned tries;
      tries = 0;
      void'(trace_path(maze_cells, marks, steps));
      while (steps > MAX_STEPS) begin
         if (tries < 3)
            send_item(CMD_LOAD, ROW_IDX_W'($urandom),
                      CELLS_W'($urandom & $urandom & $urandom));
         else
            send_item(CMD_LOAD, ROW_IDX_W'(1), '0);
         tries++;
         void'(trace_path(maze_cells, marks, steps));
      end
      send_solve();
   endtask

   function automatic grid_type carve_maze();
      grid_type g;
      int       r;
      int       c;
      for (int i = 0; i < ROWS; i++) begin
         case ($urandom_range(0, 3))
            0:       g[i] = CELLS_W'($urandom & $urandom);
            1:       g[i] = CELLS_W'($urandom);
            2:       g[i] = CELLS_W'($urandom | $urandom);
            default: g[i] = '0;
         endcase
      end
      r       = 0;
      c       = 0;
      g[0][0] = 1'b1;
      while (!(r == ROWS-1 && c == COLS-1)) begin
         if (r == ROWS-1 || (c < COLS-1 && $urandom_range(0, 2) != 0)) c++;
         else r++;
         g[r][c] = 1'b1;
      end
      return g;
   endfunction

   task automatic test_cleared_grid();
      send_solve();
   endtask

   task automatic test_open_grid();
      for (int r = 0; r < ROWS; r++) send_item(CMD_LOAD, ROW_IDX_W'(r), '1);
      send_solve();
   endtask

   task automatic test_goal_wall();
      send_item(CMD_LOAD, ROW_IDX_W'(ROWS-1), CELLS_W'(16'h7fff));
      send_solve();
   endtask

   task automatic test_start_wall();
      send_item(CMD_LOAD, '0, CELLS_W'(16'hfffe));
      send_solve();
   endtask

   task automatic test_blocked_row();
      send_item(CMD_LOAD, '0, '1);
      send_item(CMD_LOAD, ROW_IDX_W'(1), '0);
      send_solve();
   endtask

   task automatic test_random_mazes();
      int unsigned first;
      int unsigned round;
      int unsigned kind;
      int          order[ROWS];
      int          j;
      int          tmp;
      grid_type    g;
      first = items_sent;
      round = 0;
      while (items_sent - first < 230) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         kind    = $urandom_range(0, 9);
         if (kind <= 5) begin
            g = carve_maze();
            // break some of the mazes: a cut at a random cell, a walled start or goal
            case ($urandom_range(0, 5))
               0: g[$urandom_range(0, ROWS-1)][$urandom_range(0, COLS-1)] = 1'b0;
               1: g[0][0] = 1'b0;
               2: g[ROWS-1][COLS-1] = 1'b0;
               default: ;
            endcase
            for (int i = 0; i < ROWS; i++) order[i] = i;
            for (int i = ROWS-1; i > 0; i--) begin
               j        = $urandom_range(0, i);
               tmp      = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            for (int i = 0; i < ROWS; i++)
               send_item(CMD_LOAD, ROW_IDX_W'(order[i]), g[order[i]]);
            solve_maze();
         end else if (kind <= 7) begin
            repeat ($urandom_range(1, 3))
               send_item(CMD_LOAD, ROW_IDX_W'($urandom), CELLS_W'($urandom));
            solve_maze();
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 4))
               send_item(CMD_LOAD, ROW_IDX_W'($urandom), CELLS_W'($urandom));
         end else begin
            solve_maze();
         end
         if (round % 9 == 4) wait_for_rows();
         round++;
      end
      no_gaps = 1'b0;
   endtask

   // sink side: may stall before a transfer, never when no_gaps is set
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rows
      path_row_type got;
      path_row_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grid_path_backtracking_solver: mismatch");
         $finish;
      end else if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.found  = rsp_chan.found;
         got.row    = rsp_chan.out_row;
         got.bits   = rsp_chan.path_bits;
         got.length = rsp_chan.path_length;
         got.last   = rsp_chan.last_row;
         stall_left = no_gaps ? 0 : $urandom_range(0, 12);
         if (path_rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected row %0d: found %0b bits %h len %0d last %0b",
                        got.row, got.found, got.bits, got.length, got.last);
         end else begin
            want = path_rows_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"row %0d: want found %0b bits %h len %0d last %0b, ",
                            "got row %0d found %0b bits %h len %0d last %0b"},
                           want.row, want.found, want.bits, want.length, want.last,
                           got.row, got.found, got.bits, got.length, got.last);
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_LOAD;
      req_chan.row_index = '0;
      req_chan.row_cells = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_cleared_grid();
      test_open_grid();
      test_goal_wall();
      test_start_wall();
      test_blocked_row();
      test_random_mazes();

      wait_for_rows();
      // give a stray transfer time to show up
      repeat (60) @(posedge clock);
      if (mismatches == 0 && path_rows_due.size() == 0) begin
         $display("grid_path_backtracking_solver: match");
      end else begin
         $display("grid_path_backtracking_solver: mismatch");
      end
      $finish;
   end

endmodule
